/* rtl/pfsa_pkg.sv */
// Shared types, constants and codes for the sequence log-likelihood block.
// No dependencies; every other file but pfsa_checker imports this package.
package pfsa_pkg;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int SYM_W     = 8;
  localparam int STATE_W   = 6;
  localparam int VALUE_W   = 24;
  localparam int FLOOR_W   = 8;
  localparam int MEAN_W    = 29;
  localparam int CNT_OUT_W = 24;

  // Number formats
  localparam int PROB_FRAC_BITS = 24;
  localparam int LOG_FRAC       = 24;
  localparam int SUM_W          = 56;

  // Parameter defaults
  localparam int STATES_DEF     = 8;
  localparam int SYMBOLS_DEF    = 4;
  localparam int COUNT_BITS_DEF = 24;

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 8'd2;
  localparam logic [SUM_W-1:0]   ZERO_TERM   = SUM_W'(29'h1FFF_FFFF);
  localparam logic [MEAN_W-1:0]  MEAN_MAX    = '1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_TRANS = 2'd0,
    OP_LOAD_EMIT  = 2'd1,
    OP_LOAD_START = 2'd2,
    OP_SYMBOL     = 2'd3
  } op_t;

  // Command class decided by the front end
  typedef enum logic [2:0] {
    K_NOP,
    K_TRANS,
    K_EMIT,
    K_START,
    K_SYMBOL
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic                sym_ok;
    logic [SYM_W-1:0]    symbol;
    logic [STATE_W-1:0]  from_state;
    logic [STATE_W-1:0]  to_state;
    logic [VALUE_W-1:0]  value;
    logic                last;
  } cmd_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_MAC,
    B_DRAIN,
    B_DIV_START,
    B_DIV_WAIT,
    B_TERM,
    B_MEAN_START,
    B_MEAN_WAIT,
    B_OUT
  } back_state_t;

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_SQUARE
  } log_state_t;

  typedef enum logic {
    D_IDLE,
    D_RUN
  } div_state_t;

endpackage

/* rtl/pfsa_if.sv */
// Valid/ready channel interfaces: input items, results, configuration writes.
// Depends on pfsa_pkg for field widths.
interface pfsa_in_if import pfsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [SYM_W-1:0]   symbol;
  logic [STATE_W-1:0] from_state;
  logic [STATE_W-1:0] to_state;
  logic [VALUE_W-1:0] value;
  logic               last;
  modport source (output valid, op, symbol, from_state, to_state, value, last, input ready);
  modport sink (input valid, op, symbol, from_state, to_state, value, last, output ready);
endinterface

interface pfsa_out_if import pfsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MEAN_W-1:0]    neg_avg_log2;
  logic                 zero_probability_seen;
  logic [CNT_OUT_W-1:0] symbol_count;
  modport source (output valid, neg_avg_log2, zero_probability_seen, symbol_count,
                  input ready);
  modport sink (input valid, neg_avg_log2, zero_probability_seen, symbol_count,
                output ready);
endinterface

interface pfsa_cfg_if import pfsa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FLOOR_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/pfsa_front.sv */
// Front end: accepts input words, classifies them and queues commands.
// Depends on pfsa_pkg and pfsa_in_if.
module pfsa_front import pfsa_pkg::*; #(
  parameter int STATES  = STATES_DEF,
  parameter int SYMBOLS = SYMBOLS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pfsa_in_if.sink   items,
  output cmd_t      cmd,
  output logic      cmd_valid,
  input  logic      cmd_pop
);

  localparam int QDEPTH = 2;

  cmd_t       q [QDEPTH];
  logic       wptr, rptr;
  logic [1:0] cnt;
  cmd_t       cls;
  logic       sym_ok, fs_ok, ts_ok, push, pop;

  // Range checks
  assign sym_ok = {1'b0, items.symbol} < 9'(SYMBOLS);
  assign fs_ok  = {1'b0, items.from_state} < 7'(STATES);
  assign ts_ok  = {1'b0, items.to_state} < 7'(STATES);

  // Classification
  always_comb begin
    cls            = '0;
    cls.sym_ok     = sym_ok;
    cls.symbol     = items.symbol;
    cls.from_state = items.from_state;
    cls.to_state   = items.to_state;
    cls.value      = items.value;
    cls.last       = items.last;
    case (op_t'(items.op))
      OP_LOAD_TRANS: cls.kind = (sym_ok && fs_ok && ts_ok) ? K_TRANS : K_NOP;
      OP_LOAD_EMIT:  cls.kind = (sym_ok && fs_ok) ? K_EMIT : K_NOP;
      OP_LOAD_START: cls.kind = fs_ok ? K_START : K_NOP;
      OP_SYMBOL:     cls.kind = K_SYMBOL;
      default:       cls.kind = K_NOP;
    endcase
  end

  assign items.ready = (cnt != 2'(QDEPTH));
  assign push        = items.valid && items.ready;
  assign pop         = cmd_pop && cmd_valid;
  assign cmd_valid   = (cnt != 2'd0);
  assign cmd         = q[rptr];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= cls;
    end
  end

endmodule

/* rtl/pfsa_log2.sv */
// Multi-cycle -log2 unit: leading-one search then one mantissa squaring per cycle.
// Depends on pfsa_pkg.
module pfsa_log2 import pfsa_pkg::*; #(
  parameter int IN_W = 53
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [IN_W-1:0]         value,
  output logic                    busy,
  output logic signed [SUM_W-1:0] term
);

  localparam int SH_W = $clog2(IN_W + 1);
  localparam int IT_W = $clog2(LOG_FRAC + 1);

  log_state_t          st, st_next;
  logic [IN_W-1:0]     w;
  logic [SH_W-1:0]     sh;
  logic [31:0]         x;
  logic [LOG_FRAC-1:0] frac;
  logic [IT_W-1:0]     it;
  logic [63:0]         sq;
  logic [32:0]         sqs;
  logic [SUM_W-1:0]    expo;

  assign sq  = 64'(x) * 64'(x);
  assign sqs = sq[63:31];

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      L_IDLE:   if (start) st_next = L_NORM;
      L_NORM:   if (w[IN_W-1]) st_next = L_SQUARE;
      L_SQUARE: if (it == IT_W'(LOG_FRAC - 1)) st_next = L_IDLE;
      default:  st_next = L_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (st != L_IDLE);
    expo = SUM_W'(2 * PROB_FRAC_BITS) - SUM_W'(IN_W - 1) + SUM_W'(sh);
    term = signed'((expo << LOG_FRAC) - SUM_W'(frac));
  end

  always_ff @(posedge clk) begin
    if (rst) st <= L_IDLE;
    else     st <= st_next;
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (st)
      L_IDLE: begin
        if (start) begin
          w    <= value;
          sh   <= '0;
          frac <= '0;
          it   <= '0;
        end
      end
      L_NORM: begin
        if (w[IN_W-1 -: 8] == 8'd0) begin
          w  <= w << 8;
          sh <= sh + SH_W'(8);
        end else if (!w[IN_W-1]) begin
          w  <= w << 1;
          sh <= sh + SH_W'(1);
        end else begin
          x <= w[IN_W-1 -: 32];
        end
      end
      L_SQUARE: begin
        frac <= {frac[LOG_FRAC-2:0], sqs[32]};
        x    <= sqs[32] ? sqs[32:1] : sqs[31:0];
        it   <= it + IT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

/* rtl/pfsa_div.sv */
// Restoring divider, one quotient bit per cycle after a first compare step.
// Depends on pfsa_pkg. Requires rem_init < 2 * den.
module pfsa_div import pfsa_pkg::*; #(
  parameter int DW = 33,
  parameter int SW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] rem_init,
  input  logic [SW-1:0] low,
  input  logic [DW-1:0] den,
  output logic          busy,
  output logic [SW:0]   quo
);

  localparam int CW = $clog2(SW + 1);

  div_state_t    st, st_next;
  logic [DW-1:0] r;
  logic [SW-1:0] lo;
  logic [CW-1:0] cnt;
  logic [DW:0]   r2, r2_sub;
  logic          ge;

  assign r2     = {r, lo[SW-1]};
  assign ge     = r2 >= {1'b0, den};
  assign r2_sub = r2 - {1'b0, den};

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      D_IDLE:  if (start) st_next = D_RUN;
      D_RUN:   if (cnt == CW'(SW - 1)) st_next = D_IDLE;
      default: st_next = D_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy = (st == D_RUN);
  end

  always_ff @(posedge clk) begin
    if (rst) st <= D_IDLE;
    else     st <= st_next;
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (st)
      D_IDLE: begin
        if (start) begin
          r   <= (rem_init >= den) ? rem_init - den : rem_init;
          quo <= (SW+1)'(rem_init >= den);
          lo  <= low;
          cnt <= '0;
        end
      end
      D_RUN: begin
        r   <= ge ? r2_sub[DW-1:0] : r2[DW-1:0];
        quo <= {quo[SW-1:0], ge};
        lo  <= lo << 1;
        cnt <= cnt + CW'(1);
      end
      default: ;
    endcase
  end

endmodule

/* rtl/pfsa_back.sv */
// Back end: table writes, forward step (MAC pipeline, log2, normalization) and results.
// Depends on pfsa_pkg, pfsa_out_if, pfsa_log2 and pfsa_div.
module pfsa_back import pfsa_pkg::*; #(
  parameter int STATES     = STATES_DEF,
  parameter int SYMBOLS    = SYMBOLS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  logic [FLOOR_W-1:0] floor_added,
  pfsa_out_if.source         results
);

  localparam int PF     = PROB_FRAC_BITS;
  localparam int SVW    = PF + 1;
  localparam int PRODW  = VALUE_W + SVW;
  localparam int ACCW   = PRODW + $clog2(STATES + 1);
  localparam int UPDW   = ACCW - PF;
  localparam int SUMUW  = UPDW + $clog2(STATES + 1);
  localparam int IDXW   = (STATES > 1) ? $clog2(STATES) : 1;
  localparam int TDEPTH = SYMBOLS * STATES * STATES;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int EDEPTH = STATES * SYMBOLS;
  localparam int EAW    = $clog2(EDEPTH);
  localparam int CMW    = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(STATES - 1);

  back_state_t st, st_next;

  // Tables and vectors
  logic [VALUE_W-1:0] tmem [TDEPTH];
  logic [VALUE_W-1:0] emem [EDEPTH];
  logic [VALUE_W-1:0] start_vec [STATES];
  logic [SVW-1:0]     sv [STATES];
  logic [UPDW-1:0]    upd [STATES];
  logic [VALUE_W-1:0] t_rdata, e_rdata;
  logic [TAW-1:0]     t_waddr, t_raddr;
  logic [EAW-1:0]     e_waddr, e_raddr;
  logic               t_we, e_we;

  // Current symbol
  logic [SYM_W-1:0] cur_sym;
  logic             cur_ok, cur_last;

  // MAC issue and pipeline
  logic             phase_tr, issue, iss_end;
  logic [IDXW-1:0]  j, k;
  logic             s1_valid, s1_tr, s1_end;
  logic [IDXW-1:0]  s1_k;
  logic [SVW-1:0]   s1_sv;
  logic             s2_valid, s2_tr, s2_end;
  logic [IDXW-1:0]  s2_k;
  logic [PRODW-1:0] s2_prod;
  logic [VALUE_W-1:0] rd_sel;
  logic [ACCW-1:0]  acc, acc_sum, acc_floor;
  logic [SUMUW-1:0] usum;
  logic             pr_zero;

  // Sequence state
  logic signed [SUM_W-1:0] log_sum;
  logic [COUNT_BITS-1:0]   count;
  logic                    zero_flag;
  logic [MEAN_W-1:0]       mean_val;

  // Units
  logic                    log_start, log_busy;
  logic signed [SUM_W-1:0] log_term, term;
  logic                    div_start, div_busy;
  logic [PF:0]             div_quo;
  logic                    mean_start, mean_busy;
  logic [SUM_W:0]          mean_quo;
  logic signed [SUM_W:0]   ls_wide;

  // Result register
  logic                 res_valid;
  logic [MEAN_W-1:0]    res_mean;
  logic                 res_zero;
  logic [CNT_OUT_W-1:0] res_cnt;
  logic [CMW-1:0]       cnt_ext;
  logic [CNT_OUT_W-1:0] cnt_out;
  logic                 out_free;

  pfsa_log2 #(.IN_W(ACCW)) u_log2 (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .value (acc_sum),
    .busy  (log_busy),
    .term  (log_term)
  );

  pfsa_div #(.DW(SUMUW), .SW(PF)) u_div_norm (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (SUMUW'(upd[k])),
    .low      ('0),
    .den      (usum),
    .busy     (div_busy),
    .quo      (div_quo)
  );

  pfsa_div #(.DW(COUNT_BITS), .SW(SUM_W)) u_div_mean (
    .clk      (clk),
    .rst      (rst),
    .start    (mean_start),
    .rem_init ('0),
    .low      (log_sum),
    .den      (count),
    .busy     (mean_busy),
    .quo      (mean_quo)
  );

  // Addresses
  assign t_waddr = TAW'((int'(cmd.symbol) * STATES + int'(cmd.from_state)) * STATES
                        + int'(cmd.to_state));
  assign e_waddr = EAW'(int'(cmd.from_state) * SYMBOLS + int'(cmd.symbol));
  assign t_raddr = TAW'((int'(cur_sym) * STATES + int'(j)) * STATES + int'(k));
  assign e_raddr = EAW'(int'(j) * SYMBOLS + int'(cur_sym));

  // MAC datapath taps
  assign iss_end   = (j == LAST_IDX);
  assign rd_sel    = cur_ok ? (s1_tr ? t_rdata : e_rdata) : '0;
  assign acc_sum   = acc + ACCW'(s2_prod);
  assign acc_floor = acc_sum + (ACCW'(floor_added) << PF);
  assign log_start = s2_valid && s2_end && !s2_tr && (acc_sum != '0);

  // Term and saturating sum
  assign term    = pr_zero ? signed'(ZERO_TERM) : log_term;
  assign ls_wide = {log_sum[SUM_W-1], log_sum} + {term[SUM_W-1], term};

  // Count clip for the output field
  assign cnt_ext  = CMW'(count);
  assign cnt_out  = (cnt_ext > CMW'({CNT_OUT_W{1'b1}})) ? '1 : cnt_ext[CNT_OUT_W-1:0];
  assign out_free = !res_valid || results.ready;

  // Next state
  always_comb begin
    st_next = st;
    case (st)
      B_IDLE:       if (cmd_valid && cmd.kind == K_SYMBOL) st_next = B_MAC;
      B_MAC:        if (phase_tr && iss_end && k == LAST_IDX) st_next = B_DRAIN;
      B_DRAIN:      if (!s1_valid && !s2_valid) st_next = B_DIV_START;
      B_DIV_START: begin
        if (usum != '0)         st_next = B_DIV_WAIT;
        else if (k == LAST_IDX) st_next = B_TERM;
      end
      B_DIV_WAIT: begin
        if (!div_busy) st_next = (k == LAST_IDX) ? B_TERM : B_DIV_START;
      end
      B_TERM:       if (!log_busy) st_next = cur_last ? B_MEAN_START : B_IDLE;
      B_MEAN_START: st_next = (log_sum > 0) ? B_MEAN_WAIT : B_OUT;
      B_MEAN_WAIT:  if (!mean_busy) st_next = B_OUT;
      B_OUT:        if (out_free) st_next = B_IDLE;
      default:      st_next = B_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    cmd_pop    = (st == B_IDLE) && cmd_valid;
    issue      = (st == B_MAC);
    div_start  = (st == B_DIV_START) && (usum != '0);
    mean_start = (st == B_MEAN_START) && (log_sum > 0);
    t_we       = cmd_pop && (cmd.kind == K_TRANS);
    e_we       = cmd_pop && (cmd.kind == K_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) st <= B_IDLE;
    else     st <= st_next;
  end

  // Table memories
  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_waddr] <= cmd.value;
    end
    t_rdata <= tmem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      emem[e_waddr] <= cmd.value;
    end
    e_rdata <= emem[e_raddr];
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  // Start vector, MAC pipeline and accumulation
  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == K_START) begin
      start_vec[cmd.from_state[IDXW-1:0]] <= cmd.value;
    end
    if (cmd_pop && cmd.kind == K_SYMBOL) begin
      cur_sym  <= cmd.symbol;
      cur_ok   <= cmd.sym_ok;
      cur_last <= cmd.last;
      phase_tr <= 1'b0;
      j        <= '0;
      k        <= '0;
      acc      <= '0;
      usum     <= '0;
      if (count == '0) begin
        for (int i = 0; i < STATES; i++) begin
          sv[i] <= SVW'(start_vec[i]);
        end
      end
    end
    // issue stage
    if (issue) begin
      if (iss_end) begin
        j <= '0;
        if (!phase_tr) begin
          phase_tr <= 1'b1;
          k        <= '0;
        end else if (k != LAST_IDX) begin
          k <= k + IDXW'(1);
        end
      end else begin
        j <= j + IDXW'(1);
      end
    end
    s1_tr  <= phase_tr;
    s1_end <= iss_end;
    s1_k   <= k;
    s1_sv  <= sv[j];
    // multiply stage
    s2_tr   <= s1_tr;
    s2_end  <= s1_end;
    s2_k    <= s1_k;
    s2_prod <= PRODW'(rd_sel) * PRODW'(s1_sv);
    // accumulate stage
    if (s2_valid) begin
      if (s2_end) begin
        acc <= '0;
        if (!s2_tr) begin
          pr_zero <= (acc_sum == '0);
        end else begin
          upd[s2_k] <= acc_floor[ACCW-1:PF];
          usum      <= usum + SUMUW'(acc_floor[ACCW-1:PF]);
        end
      end else begin
        acc <= acc_sum;
      end
    end
    // normalization
    if (st == B_DRAIN && !s1_valid && !s2_valid) begin
      k <= '0;
    end
    if (st == B_DIV_START && usum == '0) begin
      sv[k] <= '0;
      if (k != LAST_IDX) k <= k + IDXW'(1);
    end
    if (st == B_DIV_WAIT && !div_busy) begin
      sv[k] <= div_quo;
      if (k != LAST_IDX) k <= k + IDXW'(1);
    end
    // mean
    if (st == B_MEAN_START && !(log_sum > 0)) begin
      mean_val <= '0;
    end
    if (st == B_MEAN_WAIT && !mean_busy) begin
      mean_val <= (mean_quo > (SUM_W+1)'(MEAN_MAX)) ? MEAN_MAX : mean_quo[MEAN_W-1:0];
    end
  end

  // Sequence accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      log_sum   <= '0;
      count     <= '0;
      zero_flag <= 1'b0;
    end else if (st == B_TERM && !log_busy) begin
      if (ls_wide[SUM_W] != ls_wide[SUM_W-1]) begin
        log_sum <= ls_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        log_sum <= ls_wide[SUM_W-1:0];
      end
      if (pr_zero) zero_flag <= 1'b1;
      if (count != '1) count <= count + COUNT_BITS'(1);
    end else if (st == B_OUT && out_free) begin
      log_sum   <= '0;
      count     <= '0;
      zero_flag <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (st == B_OUT && out_free) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == B_OUT && out_free) begin
      res_mean <= mean_val;
      res_zero <= zero_flag;
      res_cnt  <= cnt_out;
    end
  end

  assign results.valid                 = res_valid;
  assign results.neg_avg_log2          = res_mean;
  assign results.zero_probability_seen = res_zero;
  assign results.symbol_count          = res_cnt;

endmodule

/* rtl/pfsa_sequence_log_likelihood_unit.sv */
// Usage
// Scaled forward-algorithm log-likelihood of a symbol sequence.
// Channels: items (input words: table loads and symbols), results (one word per
// finished sequence), cfg (writes floor_added; always ready).
// Load words fill the transition table, the emission table or the start vector.
// A symbol word with last set ends the sequence and yields one result word:
// mean -log2 likelihood per symbol, zero-probability flag and symbol count.
// A load is written to its table when the back end pops it from the queue.
// A symbol holds the back end while the MAC pipeline (one multiply per cycle)
// and the bit-serial normalization divider work through it; the last symbol
// also runs the mean divider and the output step. One word is worked on at a
// time; a two-word queue lets items be accepted while the back end is busy.
// Reset clears the queue, the sequence sums and the result register; tables
// keep their contents and must be loaded before use.
// A stalled receiver holds the result register; the block then stops after the
// next finished sequence until the result is taken.
// Depends on pfsa_pkg, pfsa_if, pfsa_front and pfsa_back.
module pfsa_sequence_log_likelihood_unit import pfsa_pkg::*; #(
  parameter int STATES     = STATES_DEF,
  parameter int SYMBOLS    = SYMBOLS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pfsa_in_if.sink     items,
  pfsa_out_if.source  results,
  pfsa_cfg_if.sink    cfg
);

  cmd_t               cmd;
  logic               cmd_valid, cmd_pop;
  logic [FLOOR_W-1:0] floor_added;

  // Floor register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_added <= FLOOR_RESET;
    end else if (cfg.valid) begin
      floor_added <= cfg.data;
    end
  end

  pfsa_front #(.STATES(STATES), .SYMBOLS(SYMBOLS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  pfsa_back #(.STATES(STATES), .SYMBOLS(SYMBOLS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .floor_added (floor_added),
    .results     (results)
  );

endmodule

/* rtl/pfsa_checker.sv */
// Port-level checks on the top level, attached by bind.
// Depends on pfsa_sequence_log_likelihood_unit ports only.
module pfsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [28:0] res_mean,
  input logic        res_zero,
  input logic [23:0] res_cnt
);

  // Stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_mean) && $stable(res_zero)
                                && $stable(res_cnt))
    else $error("result word changed while stalled");

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Every result covers at least one symbol
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_cnt != 24'd0)
    else $error("result with zero symbol count");

endmodule

bind pfsa_sequence_log_likelihood_unit pfsa_checker u_pfsa_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_mean  (results.neg_avg_log2),
  .res_zero  (results.zero_probability_seen),
  .res_cnt   (results.symbol_count)
);
